// ===== hw/rtl/tett_pkg.sv =====
`timescale 1ns / 1ps

package tett_pkg;

  // Fixed field widths of the request and response items
  localparam int TAG_BITS         = 16;
  localparam int ITEM_PAYLOAD_BITS = 32;
  localparam int COUNT_BITS       = 8;
  localparam int STATUS_BITS      = 2;
  localparam int PAYLOAD_MAX_BITS = 64;

  // Parameter defaults
  localparam int TABLE_DEPTH_DEF  = 16;
  localparam int PAYLOAD_BITS_DEF = 32;

  // Operation codes
  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_TAKE = 1'b1;

  // Result status codes
  localparam logic [STATUS_BITS-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_BITS-1:0] STATUS_FULL      = 2'd1;
  localparam logic [STATUS_BITS-1:0] STATUS_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic                         mode;
    logic [TAG_BITS-1:0]          search_tag;
    logic [ITEM_PAYLOAD_BITS-1:0] entry_payload;
  } tett_req_t;

  typedef struct packed {
    logic [STATUS_BITS-1:0]       status;
    logic [ITEM_PAYLOAD_BITS-1:0] taken_payload;
    logic [COUNT_BITS-1:0]        entry_count;
  } tett_rsp_t;

  // Broadcast strobes from the controller to every cell
  typedef struct packed {
    logic capture;  // latch tag compare for the accepted transaction
    logic push;     // append at the tail cell
    logic take;     // close the gap above the first hit
  } tett_ctrl_t;

endpackage

// ===== hw/rtl/tett_stream_if.sv =====
`timescale 1ns / 1ps

interface tett_stream_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/tett_cell.sv =====
`timescale 1ns / 1ps

module tett_cell import tett_pkg::*; #(
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
  input  logic                    clk,
  input  tett_ctrl_t              ctrl,
  input  logic [TAG_BITS-1:0]     cmp_tag,
  input  logic [TAG_BITS-1:0]     wr_tag,
  input  logic [PAYLOAD_BITS-1:0] wr_payload,
  input  logic                    occupied,
  input  logic                    is_tail,
  input  logic                    hit_below,
  input  logic [TAG_BITS-1:0]     nb_tag,
  input  logic [PAYLOAD_BITS-1:0] nb_payload,
  output logic [TAG_BITS-1:0]     tag,
  output logic [PAYLOAD_BITS-1:0] payload,
  output logic                    hit,
  output logic [PAYLOAD_BITS-1:0] pick
);

  // Capture the compare result when a transaction is accepted
  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      hit <= occupied && (tag == cmp_tag);
    end
  end

  // Load on push at the tail, shift down from the neighbor on take
  always_ff @(posedge clk) begin
    if (ctrl.push && is_tail) begin
      tag     <= wr_tag;
      payload <= wr_payload;
    end else if (ctrl.take && (hit || hit_below)) begin
      tag     <= nb_tag;
      payload <= nb_payload;
    end
  end

  // Offer the payload only from the oldest matching cell
  assign pick = (hit && !hit_below) ? payload : '0;

endmodule

// ===== hw/rtl/tagged_entry_take_table_unit.sv =====
`timescale 1ns / 1ps
// The tag compare in the cell row is registered when a request is accepted; the push or
// gap-closing shift and the response load follow in the execute state, which waits while a
// held response is not taken. No new request is accepted until the current one commits.
// Reset: clears the entry count, the sequencer and the response valid; the table
// contents stay undefined until written.
module tagged_entry_take_table_unit import tett_pkg::*; #(
  parameter int TABLE_DEPTH  = TABLE_DEPTH_DEF,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  tett_stream_if.sink   req,
  tett_stream_if.source rsp
);

  localparam int CntBits = $clog2(TABLE_DEPTH + 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic                    state;
  logic                    state_next;
  logic [CntBits-1:0]      count;
  logic [CntBits-1:0]      count_next;
  logic                    op_mode;
  logic [TAG_BITS-1:0]     op_tag;
  logic [PAYLOAD_BITS-1:0] op_payload;
  logic                    out_valid;
  tett_rsp_t               out_data;
  tett_rsp_t               out_data_next;

  logic                    req_fire;
  logic                    exec_fire;
  logic                    found;
  logic [PAYLOAD_BITS-1:0] taken;
  logic [PAYLOAD_MAX_BITS-1:0] req_payload_wide;
  logic [PAYLOAD_MAX_BITS-1:0] taken_wide;
  tett_ctrl_t              ctrl;

  logic [TABLE_DEPTH-1:0]  hits;
  logic [TABLE_DEPTH-1:0]  hit_below;
  logic [TABLE_DEPTH-1:0]  occupied;
  logic [TABLE_DEPTH-1:0]  is_tail;
  logic [TAG_BITS-1:0]     cell_tag     [TABLE_DEPTH];
  logic [PAYLOAD_BITS-1:0] cell_payload [TABLE_DEPTH];
  logic [PAYLOAD_BITS-1:0] cell_pick    [TABLE_DEPTH];

  // Handshake
  assign req_fire  = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign exec_fire = (state == S_EXEC) && (!out_valid || rsp.ready);
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  assign ctrl.capture = req_fire;
  assign ctrl.push    = exec_fire && (op_mode == MODE_PUSH);
  assign ctrl.take    = exec_fire && (op_mode == MODE_TAKE);

  assign req_payload_wide = PAYLOAD_MAX_BITS'(req.data.entry_payload);

  // Latch the accepted request
  always_ff @(posedge clk) begin
    if (req_fire) begin
      op_mode    <= req.data.mode;
      op_tag     <= req.data.search_tag;
      op_payload <= req_payload_wide[PAYLOAD_BITS-1:0];
    end
  end

  // Row of cells; on a take, each cell at or above the oldest hit takes its younger neighbor's entry
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    assign occupied[i] = (CntBits'(i) < count);
    assign is_tail[i]  = (CntBits'(i) == count);

    if (i == 0) begin : g_first
      assign hit_below[i] = 1'b0;
    end else begin : g_rest
      assign hit_below[i] = |hits[i-1:0];
    end

    if (i == TABLE_DEPTH - 1) begin : g_last
      tett_cell #(.PAYLOAD_BITS(PAYLOAD_BITS)) u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .cmp_tag    (req.data.search_tag),
        .wr_tag     (op_tag),
        .wr_payload (op_payload),
        .occupied   (occupied[i]),
        .is_tail    (is_tail[i]),
        .hit_below  (hit_below[i]),
        .nb_tag     (cell_tag[i]),
        .nb_payload (cell_payload[i]),
        .tag        (cell_tag[i]),
        .payload    (cell_payload[i]),
        .hit        (hits[i]),
        .pick       (cell_pick[i])
      );
    end else begin : g_mid
      tett_cell #(.PAYLOAD_BITS(PAYLOAD_BITS)) u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .cmp_tag    (req.data.search_tag),
        .wr_tag     (op_tag),
        .wr_payload (op_payload),
        .occupied   (occupied[i]),
        .is_tail    (is_tail[i]),
        .hit_below  (hit_below[i]),
        .nb_tag     (cell_tag[i+1]),
        .nb_payload (cell_payload[i+1]),
        .tag        (cell_tag[i]),
        .payload    (cell_payload[i]),
        .hit        (hits[i]),
        .pick       (cell_pick[i])
      );
    end
  end

  // Gather the payload of the oldest hit
  always_comb begin
    taken = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      taken = taken | cell_pick[i];
    end
  end

  assign found      = |hits;
  assign taken_wide = PAYLOAD_MAX_BITS'(taken);

  // Build the response and the next count
  always_comb begin
    count_next    = count;
    out_data_next = '0;
    if (op_mode == MODE_PUSH) begin
      if (count == CntBits'(TABLE_DEPTH)) begin
        out_data_next.status = STATUS_FULL;
      end else begin
        count_next           = count + CntBits'(1);
        out_data_next.status = STATUS_OK;
      end
    end else begin
      if (found) begin
        count_next                  = count - CntBits'(1);
        out_data_next.status        = STATUS_OK;
        out_data_next.taken_payload = taken_wide[ITEM_PAYLOAD_BITS-1:0];
      end else begin
        out_data_next.status = STATUS_NOT_FOUND;
      end
    end
    out_data_next.entry_count = COUNT_BITS'(count_next);
  end

  // Sequencer: compare on accept, then commit when the response slot is free
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_fire) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (exec_fire) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (exec_fire) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Hold the response payload
  always_ff @(posedge clk) begin
    if (exec_fire) begin
      out_data <= out_data_next;
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntBits'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_single_pick: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC) |-> $onehot0(hits & ~hit_below))
    else $error("more than one oldest hit");

  a_take_shrinks: assert property (@(posedge clk) disable iff (rst)
    (ctrl.take && found) |=> (count == $past(count) - CntBits'(1)))
    else $error("successful take did not remove one entry");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (ctrl.push && (count != CntBits'(TABLE_DEPTH))) |=> (count == $past(count) + CntBits'(1)))
    else $error("push into free slot did not add one entry");

  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_EXEC))
    else $error("response raised without a commit");

endmodule
